[hdl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[hdl/lpat_pkg.sv]
// Types, constants and the arctangent table for the lidar azimuth stamper.
// No dependencies.
package lpat_pkg;
   localparam int ColumnsPerRow = 360;
   localparam int RowCount      = 18;
   localparam int AngleBits     = 16;
   localparam int CordicSteps   = 24;
   localparam int CordicW       = 34;
   localparam int AngleW        = 34;
   localparam int StepW         = $clog2(CordicSteps);
   localparam int ColW          = $clog2(ColumnsPerRow);
   localparam int RowW          = (RowCount > 1) ? $clog2(RowCount) : 1;
   localparam logic [31:0] DefaultIntensity = 32'h42C8_0000;
   localparam logic [23:0] ScanPeriodReset  = 24'd100000;

   typedef struct packed {
      logic [31:0] x_bits;
      logic [31:0] y_bits;
      logic [31:0] z_bits;
      logic [31:0] intensity_bits;
      logic [15:0] ring_in;
      logic        ring_present;
      logic        intensity_present;
      logic        cloud_start;
   } req_type;

   typedef struct packed {
      logic [31:0] x_out;
      logic [31:0] y_out;
      logic [31:0] z_out;
      logic [31:0] intensity_out;
      logic [23:0] time_us;
      logic [15:0] ring_out;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
      logic busy;
   } cordic_ctl_type;

   function automatic logic [29:0] atan_turn(input logic [StepW-1:0] i);
      logic [29:0] v;
      case (i)
         5'd0: v = 30'd536870912;  5'd1: v = 30'd316933406;
         5'd2: v = 30'd167458907;  5'd3: v = 30'd85004756;
         5'd4: v = 30'd42667331;   5'd5: v = 30'd21354465;
         5'd6: v = 30'd10679838;   5'd7: v = 30'd5340245;
         5'd8: v = 30'd2670163;    5'd9: v = 30'd1335087;
         5'd10: v = 30'd667544;    5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;    5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;     5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;     5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;      5'd19: v = 30'd1304;
         5'd20: v = 30'd652;       5'd21: v = 30'd326;
         5'd22: v = 30'd163;       5'd23: v = 30'd81;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

[hdl/lpat_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on lpat_pkg.
interface lpat_req_if;
   import lpat_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lpat_rsp_if;
   import lpat_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/lidar_point_azimuth_timestamp.sv]
// Channel  | dir | transfer when
// req_     | in  | req.valid & req.ready
// rsp_     | out | rsp.valid & rsp.ready
// csr_     | in  | csr_we (scan period, 24 bits)
// An item holds the block from capture until its response is taken:
// capture, alignment, CORDIC launch, 24 micro-rotations on shared
// add/subtract units, rounding, one wait state, the multiply by the scan period
// into the output register, then the response transfer.
// Two zero coordinates skip the CORDIC; a non-finite point is dropped in S_IDLE.
// Reset is synchronous and active high; it clears the sequencer, point index
// and restores the scan period to 100000 us.
// A stalled response holds in the output register and blocks the next request.
// Depends on lpat_pkg, lpat_if, lpat_cordic and assert_macros.svh.
`include "assert_macros.svh"
module lidar_point_azimuth_timestamp (
   input  logic        clock,
   input  logic        reset,
   lpat_req_if.sink    req,
   lpat_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);
   import lpat_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_PREP = 5'b00010, S_ROT = 5'b00100,
      S_MUL  = 5'b01000, S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [23:0] period_ff, period_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [15:0] ring_ff, ring_in;
   logic        zero_ff, zero_in;
   logic signed [CordicW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [AngleBits:0] frac_ff, frac_in;
   logic        start;
   logic signed [AngleW-1:0] z_init, z_res;
   logic signed [CordicW-1:0] x_init, y_init;
   cordic_ctl_type cctl;
   logic        accept, fin;
   logic [7:0]  ex, ey, dxy, dyx;
   logic [29:0] ax, ay;
   logic signed [AngleW-1:0] zr;
   logic [AngleBits:0] fr;
   logic [AngleBits+24-1:0] prod;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign fin = !(&req.data.x_bits[30:23]) && !(&req.data.y_bits[30:23])
                && !(&req.data.z_bits[30:23]);

   // Align mantissas: hidden bit, shift left 6, shift the smaller exponent right.
   always_comb begin
      ex = (item_ff.x_bits[30:23] == 8'd0) ? 8'd1 : item_ff.x_bits[30:23];
      ey = (item_ff.y_bits[30:23] == 8'd0) ? 8'd1 : item_ff.y_bits[30:23];
      ax = {(item_ff.x_bits[30:23] != 8'd0), item_ff.x_bits[22:0], 6'd0};
      ay = {(item_ff.y_bits[30:23] != 8'd0), item_ff.y_bits[22:0], 6'd0};
      dxy = ex - ey; dyx = ey - ex;
      if (ex > ey) ay = (dxy >= 8'd40) ? 30'd0 : (ay >> dxy);
      else if (ey > ex) ax = (dyx >= 8'd40) ? 30'd0 : (ax >> dyx);
   end

   // Reflect into the right half plane, seed angle with +/- half turn.
   always_comb begin
      x_init = mx_ff; y_init = my_ff; z_init = '0;
      if (mx_ff < 0) begin
         x_init = -mx_ff; y_init = -my_ff;
         z_init = item_ff.y_bits[31] ? -(AngleW'(1) <<< 31) : (AngleW'(1) <<< 31);
      end
   end

   lpat_cordic u_cordic (
      .clock, .reset, .start, .x_init, .y_init, .z_init,
      .z_result(z_res), .ctl(cctl)
   );

   always_comb begin
      zr = z_res + (AngleW'(1) <<< 31);
      if (zr < 0) zr = '0;
      fr = (AngleBits+1)'((zr + (AngleW'(1) <<< (31 - AngleBits))) >>> (32 - AngleBits));
      if (fr[AngleBits]) fr = {1'b0, {AngleBits{1'b1}}};
   end
   assign prod = frac_ff[AngleBits-1:0] * period_ff;

   always_comb begin
      state_in = state_ff; item_in = item_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff; period_in = period_ff;
      col_in = col_ff; row_in = row_ff; ring_in = ring_ff;
      zero_in = zero_ff; mx_in = mx_ff; my_in = my_ff; frac_in = frac_ff;
      start = 1'b0;
      if (csr_we) period_in = csr_wdata;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (accept) begin
            item_in = req.data;
            // Advance the point index on every transfer, dropped or kept.
            if (req.data.cloud_start) begin
               col_in = '0; row_in = '0;
            end
            ring_in = req.data.ring_present ? req.data.ring_in
                    : 16'(req.data.cloud_start ? '0 : row_ff);
            if (req.data.cloud_start || col_ff == ColW'(ColumnsPerRow - 1)) begin
               col_in = req.data.cloud_start ? ColW'(1 % ColumnsPerRow) : '0;
               if (!req.data.cloud_start)
                  row_in = (row_ff == RowW'(RowCount - 1)) ? '0 : row_ff + 1'b1;
               else if (ColumnsPerRow == 1)
                  row_in = RowW'(1 % RowCount);
            end else col_in = col_ff + 1'b1;
            if (fin) state_in = S_PREP;
         end
         S_PREP: begin
            mx_in = item_ff.x_bits[31] ? -CordicW'(ax) : CordicW'(ax);
            my_in = item_ff.y_bits[31] ? -CordicW'(ay) : CordicW'(ay);
            zero_in = (ax == 30'd0) && (ay == 30'd0);
            state_in = S_ROT;
         end
         S_ROT: begin
            if (zero_ff) begin
               frac_in = (AngleBits+1)'(1) << (AngleBits - 1);
               state_in = S_MUL;
            end else if (!cctl.busy && !cctl.done) start = 1'b1;
            else if (cctl.done) begin
               frac_in = fr; state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_OUT;
         S_OUT: if (!rsp_valid_ff) begin
            rsp_in.x_out = item_ff.x_bits;
            rsp_in.y_out = item_ff.y_bits;
            rsp_in.z_out = item_ff.z_bits;
            rsp_in.intensity_out = item_ff.intensity_present ?
                                   item_ff.intensity_bits : DefaultIntensity;
            rsp_in.time_us = prod[AngleBits +: 24];
            rsp_in.ring_out = ring_ff;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; rsp_ff <= rsp_in; ring_ff <= ring_in;
      zero_ff <= zero_in; mx_ff <= mx_in; my_ff <= my_in; frac_ff <= frac_in;
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; period_ff <= ScanPeriodReset;
         col_ff <= '0; row_ff <= '0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in; period_ff <= period_in;
         col_ff <= col_in; row_ff <= row_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   `ASSERT_NEVER(a_col_range, clock, reset, col_ff > ColW'(ColumnsPerRow - 1))
   `ASSERT_NEVER(a_row_range, clock, reset, row_ff > RowW'(RowCount - 1))
   `ASSERT_IMPL(a_cordic_idle, clock, reset, cctl.busy |-> state_ff == S_ROT)
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> !req.ready)
endmodule

[hdl/lpat_cordic.sv]
// Iterative vectoring CORDIC: one micro-rotation per cycle, shared adders.
// Depends on lpat_pkg.
module lpat_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [lpat_pkg::CordicW-1:0] x_init,
   input  logic signed [lpat_pkg::CordicW-1:0] y_init,
   input  logic signed [lpat_pkg::AngleW-1:0]  z_init,
   output logic signed [lpat_pkg::AngleW-1:0]  z_result,
   output lpat_pkg::cordic_ctl_type          ctl
);
   import lpat_pkg::*;

   logic signed [CordicW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AngleW-1:0]  z_ff, z_in;
   logic [StepW-1:0]          step_ff, step_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic signed [CordicW-1:0] xs, ys;
   logic signed [AngleW-1:0]  a;

   always_comb begin
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      a  = AngleW'(atan_turn(step_ff));
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         x_in = x_init; y_in = y_init; z_in = z_init;
         step_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!y_ff[CordicW-1]) begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + a;
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - a;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(CordicSteps - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      if (reset) begin
         step_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         step_ff <= step_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign z_result  = z_ff;
   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign ctl.busy  = busy_ff;
endmodule
